// ----- rtl/sha256_stream_hasher_defines.svh -----
// assertion macros for the sha256 stream hasher checker
// used by the checker file only
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// implication checked every edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked every edge outside reset
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sha_pkg.sv -----
// shared types, constants and functions of the sha256 stream hasher
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        JOB_DATA = 2'd0,
        JOB_FINAL = 2'd1
    } job_kind_t;

    typedef struct packed {
        job_kind_t    kind;
        logic [511:0] block;
    } job_t;

    typedef logic [31:0] word_t;

    localparam word_t [0:7] InitH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t [0:63] RoundK = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_if.sv -----
// valid/ready stream channels for the input and result beats
// depends on nothing
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] message_byte;
    modport source (output valid, action, message_byte, input ready);
    modport sink (input valid, action, message_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sha_front.sv -----
// front end: packs bytes into blocks, pads on finish, issues block jobs
// depends on sha_pkg and sha_if
`timescale 1ns / 1ps
module sha_front
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha_in_if.sink       in_ch,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_PAD,
        ST_ISSUE
    } state_t;

    state_t        state_reg;
    logic [511:0]  buf_reg;
    logic [5:0]    fill_reg;
    logic [63:0]   count_reg;
    logic          final_reg;
    logic          second_reg;
    logic [63:0]   bits_w;
    logic [511:0]  pad_block;
    logic          accept;

    assign in_ch.ready = (state_reg == ST_TAKE) && !final_reg;
    assign accept = in_ch.valid && in_ch.ready;
    assign job_valid = (state_reg == ST_ISSUE);
    assign job.kind = final_reg ? JOB_FINAL : JOB_DATA;
    assign job.block = buf_reg;
    assign bits_w = {count_reg[60:0], 3'b000};

    // bytes at and above the fill count become 0x80 then zeros
    always_comb
    begin
        pad_block = buf_reg;
        for (int i = 0; i < BlockBytes; i++)
        begin
            if (6'(i) == fill_reg)
                pad_block[511 - 8 * i -: 8] = 8'h80;
            else if (6'(i) > fill_reg)
                pad_block[511 - 8 * i -: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
            fill_reg <= '0;
            count_reg <= '0;
            final_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_TAKE:
                begin
                    if (accept)
                    begin
                        if (!in_ch.action)
                        begin
                            buf_reg[511 - 8 * fill_reg -: 8] <= in_ch.message_byte;
                            fill_reg <= fill_reg + 6'd1;
                            count_reg <= count_reg + 64'd1;
                            if (fill_reg == 6'd63)
                                state_reg <= ST_ISSUE;
                        end
                        else
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    if (second_reg)
                    begin
                        buf_reg <= {448'd0, bits_w};
                        final_reg <= 1'b1;
                    end
                    else if (fill_reg >= 6'd56)
                    begin
                        buf_reg <= pad_block;
                        second_reg <= 1'b1;
                    end
                    else
                    begin
                        buf_reg <= {pad_block[511:64], bits_w};
                        final_reg <= 1'b1;
                    end
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    if (job_ready)
                    begin
                        if (final_reg)
                        begin
                            final_reg <= 1'b0;
                            second_reg <= 1'b0;
                            fill_reg <= '0;
                            count_reg <= '0;
                            state_reg <= ST_TAKE;
                        end
                        else if (second_reg)
                            state_reg <= ST_PAD;
                        else
                            state_reg <= ST_TAKE;
                    end
                end
                default:
                    state_reg <= ST_TAKE;
            endcase
        end
    end

endmodule

// ----- rtl/sha_queue.sv -----
// two-entry job queue between front and back
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_queue
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       mem_reg [QueueDepth];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'(QueueDepth));
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_job = mem_reg[rd_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/sha_core.sv -----
// back end: one round per cycle compression, digest word output
// depends on sha_pkg and sha_if
`timescale 1ns / 1ps
module sha_core
    import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    sha_out_if.source out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    word_t        h_reg [8];
    word_t        v_reg [8];
    word_t        w_reg [16];
    logic [5:0]   round_reg;
    logic         final_reg;
    logic [2:0]   idx_reg;
    word_t        s0, s1, w_new, t1, t2, e, a;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_EMIT);
    assign out_ch.digest_word = h_reg[idx_reg];
    assign out_ch.word_index = idx_reg;
    assign out_ch.last_word = (idx_reg == 3'd7);

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundK[round_reg] + w_reg[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            idx_reg <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= InitH[i];
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        for (int i = 0; i < 16; i++)
                            w_reg[i] <= job.block[511 - 32 * i -: 32];
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                        final_reg <= (job.kind == JOB_FINAL);
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= w_new;
                    for (int i = 1; i < 8; i++)
                        v_reg[i] <= v_reg[i - 1];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(Rounds - 1))
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg <= '0;
                    state_reg <= final_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'(DigestWords - 1))
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= InitH[i];
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// sha-256 stream hasher top level: front end, job queue, compression core
// depends on sha_pkg, sha_if, sha_front, sha_queue, sha_core
`timescale 1ns / 1ps
// usage:
// in_ch carries one beat per message byte (action 0) or a finish beat
// (action 1). out_ch carries eight digest word beats after each finish,
// word_index 0 first, last_word high on the eighth.
// the front end takes absorb beats in its take state; every 64th byte hands a
// full block to the job queue, and the front end stays in its issue state
// until the queue accepts it. the core runs one round per cycle: a block
// passes through load, the 64 rounds and add, and the core takes the next
// block only after the add. long messages are paced by the core, which is
// slower per block than the front end. finish pads in one or two blocks (two
// when the length spills into a second block); the first digest word shows
// once the core has added the last block, then one word per cycle while out_ch is ready.
// a stalled receiver holds the core in its output state; the queue then
// fills and the front end drops in_ch ready.
// reset (rst_n low, asynchronous) restores the initial hash, empties the
// queue and clears the byte count; no clearing pass is needed.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    logic fj_valid, fj_ready, qj_valid, qj_ready;
    job_t fj, qj;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(fj_valid), .push_ready(fj_ready), .push_job(fj),
        .pop_valid(qj_valid), .pop_ready(qj_ready), .pop_job(qj)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
        .out_ch(out_ch)
    );

endmodule

// ----- rtl/sha_checker.sv -----
// port-level checks of the sha256 stream hasher
// depends on sha256_stream_hasher_defines.svh and the top level
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word,
    input logic [31:0] digest_word
);

    `SHA_ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid, (last_word == (word_index == 3'd7)), "last_word mismatch")
    `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1), "digest words not consecutive")
    `SHA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word), "stalled word changed")

endmodule

bind sha256_stream_hasher sha_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .last_word(out_ch.last_word),
    .digest_word(out_ch.digest_word)
);
